[sv/vna_pkg.sv]
`default_nettype none
package vna_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_FACES_DEF    = 2048;

    // Width of one coordinate, one corner index and the Q1.14 normal.
    localparam int COORD_W  = 32;
    localparam int CORNER_W = 10;
    localparam int NORM_W   = 16;
    localparam int FCOUT_W  = 12;

    typedef enum logic [1:0] {
        MODE_VERTEX = 2'd0,
        MODE_FACE   = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NEW    = 2'd3
    } vna_mode_t;

    typedef struct packed {
        vna_mode_t                   mode;
        logic signed [COORD_W-1:0]   coord_x;
        logic signed [COORD_W-1:0]   coord_y;
        logic signed [COORD_W-1:0]   coord_z;
        logic        [CORNER_W-1:0]  corner_a;
        logic        [CORNER_W-1:0]  corner_b;
        logic        [CORNER_W-1:0]  corner_c;
    } vna_item_t;

    typedef struct packed {
        logic        [CORNER_W-1:0]  vertex_id;
        logic signed [NORM_W-1:0]    normal_x;
        logic signed [NORM_W-1:0]    normal_y;
        logic signed [NORM_W-1:0]    normal_z;
        logic        [FCOUT_W-1:0]   face_count;
        logic                        degenerate;
    } vna_result_t;

    // What the normalising unit hands back to the face walker.
    typedef struct packed {
        logic                        done;
        logic signed [NORM_W-1:0]    normal_x;
        logic signed [NORM_W-1:0]    normal_y;
        logic signed [NORM_W-1:0]    normal_z;
        logic                        degenerate;
    } vna_norm_t;

    typedef enum logic [3:0] {
        W_IDLE,
        W_FACE,
        W_FCHK,
        W_VA,
        W_VB,
        W_VC,
        W_DIFF,
        W_MUL,
        W_NEXT,
        W_NSTART,
        W_NORM,
        W_OUT
    } vna_walk_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DIV,
        N_DONE
    } vna_nstate_t;

endpackage
`default_nettype wire

[sv/vna_ram.sv]
`default_nettype none
module vna_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[sv/vna_norm.sv]
`default_nettype none
module vna_norm #(
    parameter int SUM_W = 80
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [SUM_W-1:0] sum_x,
    input  wire logic signed [SUM_W-1:0] sum_y,
    input  wire logic signed [SUM_W-1:0] sum_z,
    output vna_pkg::vna_norm_t           res
);
    import vna_pkg::*;

    localparam int MAG_W = 30;
    localparam int SQ_W  = 62;
    localparam int RT_W  = 31;
    localparam int NUM_W = 45;
    localparam int DCNT_W = $clog2(NUM_W);

    vna_nstate_t state_reg, state_next;

    logic        [SUM_W-1:0]  mag_reg [3];
    logic                     neg_reg [3];
    logic        [1:0]        k_reg;
    logic        [SQ_W-1:0]   sq_reg;
    logic        [SQ_W-1:0]   acc_reg;
    logic        [SQ_W-1:0]   rbit_reg;
    logic        [SQ_W-1:0]   root_reg;
    logic        [NUM_W-1:0]  num_reg;
    logic        [RT_W-1:0]   rem_reg;
    logic        [DCNT_W-1:0] dcnt_reg;
    logic signed [NORM_W-1:0] q_reg [3];
    logic                     degen_reg;

    logic        [SUM_W-1:0]  sum_in [3];
    logic                     big;
    logic                     any_nz;
    logic        [SQ_W:0]     trial_sq;
    logic        [RT_W-1:0]   m_val;
    logic        [RT_W:0]     trial_div;
    logic        [NUM_W-1:0]  num_init;
    logic        [NORM_W-1:0] q_mag;

    assign sum_in[0] = sum_x;
    assign sum_in[1] = sum_y;
    assign sum_in[2] = sum_z;

    always_comb
    begin
        big    = 1'b0;
        any_nz = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            big    = big | (|mag_reg[k][SUM_W-1:MAG_W]);
            any_nz = any_nz | (|mag_reg[k]);
        end
    end

    assign trial_sq  = {1'b0, root_reg} + {1'b0, rbit_reg};
    assign m_val     = root_reg[RT_W-1:0];
    assign trial_div = {rem_reg, num_reg[NUM_W-1]};
    assign num_init  = {1'b0, mag_reg[k_reg][MAG_W-1:0], 14'd0}
                     + NUM_W'(m_val[RT_W-1:1]);
    assign q_mag     = (trial_div >= {1'b0, m_val}) ? {num_reg[NORM_W-2:0], 1'b1}
                                                     : {num_reg[NORM_W-2:0], 1'b0};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    state_next = N_SHIFT;
                end
            end
            N_SHIFT:
            begin
                if (!big)
                begin
                    state_next = any_nz ? N_SQ : N_DONE;
                end
            end
            N_SQ:
            begin
                if (k_reg == 2'd3)
                begin
                    state_next = N_SQRT;
                end
            end
            N_SQRT:
            begin
                if (rbit_reg[0])
                begin
                    state_next = N_DIV;
                end
            end
            N_DIV:
            begin
                if (dcnt_reg == DCNT_W'(NUM_W) && k_reg == 2'd2)
                begin
                    state_next = N_DONE;
                end
            end
            N_DONE:
            begin
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The quotient builds up in the low bits of num_reg as the dividend
    // shifts out at the top; only the low 16 bits are kept.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            N_IDLE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    mag_reg[k] <= sum_in[k][SUM_W-1] ? (~sum_in[k] + 1'b1) : sum_in[k];
                    neg_reg[k] <= !sum_in[k][SUM_W-1] && (|sum_in[k]);
                    q_reg[k]   <= '0;
                end
                k_reg     <= 2'd0;
                acc_reg   <= '0;
                degen_reg <= 1'b1;
            end
            N_SHIFT:
            begin
                if (big)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        mag_reg[k] <= mag_reg[k] >> 1;
                    end
                end
                k_reg <= 2'd0;
            end
            N_SQ:
            begin
                if (k_reg != 2'd3)
                begin
                    sq_reg <= SQ_W'(mag_reg[k_reg][MAG_W-1:0])
                            * SQ_W'(mag_reg[k_reg][MAG_W-1:0]);
                end
                if (k_reg != 2'd0)
                begin
                    acc_reg <= acc_reg + sq_reg;
                end
                k_reg    <= k_reg + 2'd1;
                rbit_reg <= SQ_W'(1) << (SQ_W - 2);
                root_reg <= '0;
            end
            N_SQRT:
            begin
                if ({1'b0, acc_reg} >= trial_sq)
                begin
                    acc_reg  <= acc_reg - trial_sq[SQ_W-1:0];
                    root_reg <= (root_reg >> 1) + rbit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                rbit_reg <= rbit_reg >> 2;
                k_reg    <= 2'd0;
                dcnt_reg <= '0;
            end
            N_DIV:
            begin
                if (dcnt_reg == '0)
                begin
                    num_reg  <= num_init;
                    rem_reg  <= '0;
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
                else if (dcnt_reg == DCNT_W'(NUM_W))
                begin
                    q_reg[k_reg] <= neg_reg[k_reg] ? -$signed(q_mag) : $signed(q_mag);
                    k_reg        <= k_reg + 2'd1;
                    dcnt_reg     <= '0;
                    degen_reg    <= 1'b0;
                    num_reg      <= {num_reg[NUM_W-2:0], 1'b0};
                end
                else
                begin
                    if (trial_div >= {1'b0, m_val})
                    begin
                        rem_reg <= RT_W'(trial_div - {1'b0, m_val});
                        num_reg <= {num_reg[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial_div[RT_W-1:0];
                        num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
            end
            N_DONE:
            begin
                k_reg <= 2'd0;
            end
            default:
            begin
                k_reg <= 2'd0;
            end
        endcase
    end

    assign res.done       = (state_reg == N_DONE);
    assign res.normal_x   = q_reg[0];
    assign res.normal_y   = q_reg[1];
    assign res.normal_z   = q_reg[2];
    assign res.degenerate = degen_reg;

endmodule
`default_nettype wire

[sv/vertex_normal_averager.sv]
// Channel  | Handshake           | Word
// ---------+---------------------+-------------------------------------
// item     | start & !busy       | vna_item_t: mode, coords, corners
// result   | done (one cycle)    | vna_result_t: id, normal, count, flag
//
// Loads and new-object items complete without going busy. A query reads every
// stored face, and a face that uses the vertex adds three vertex reads on the
// single vertex memory port, the differences and six products on one
// multiplier. Normalising then shifts the sums right until they fit in 30 bits,
// takes a 31-step square root and makes three divisions.
// Reset clears both counts; the memories need no clearing.
// The receiver cannot stall: the result is shown for one cycle only.
`default_nettype none
module vertex_normal_averager #(
    parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
    parameter int MAX_FACES    = vna_pkg::MAX_FACES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire vna_pkg::vna_item_t item,
    output logic                    busy,
    output logic                    done,
    output vna_pkg::vna_result_t    result
);
    import vna_pkg::*;

    localparam int VA_W   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int FA_W   = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int VC_W   = $clog2(MAX_VERTICES + 1);
    localparam int FC_W   = $clog2(MAX_FACES + 1);
    localparam int CMP_W  = VC_W + CORNER_W;
    localparam int SUM_W  = 68 + FC_W;
    localparam int VW_W   = 3 * COORD_W;
    localparam int FW_W   = 3 * CORNER_W;
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;

    vna_walk_t state_reg, state_next;

    logic        [VC_W-1:0]     vcount_reg;
    logic        [FC_W-1:0]     fcount_reg;
    logic        [FC_W-1:0]     j_reg;
    logic        [FC_W-1:0]     shared_reg;
    logic        [CORNER_W-1:0] qid_reg;
    logic        [CORNER_W-1:0] i1_reg;
    logic        [CORNER_W-1:0] i2_reg;
    logic        [VW_W-1:0]     v0_reg;
    logic        [VW_W-1:0]     v1_reg;
    logic        [VW_W-1:0]     v2_reg;
    logic signed [DIFF_W-1:0]   a_reg [3];
    logic signed [DIFF_W-1:0]   b_reg [3];
    logic        [2:0]          step_reg;
    logic signed [PROD_W-1:0]   mul_reg;
    logic                       mul_vld_reg;
    logic        [2:0]          sel_reg;
    logic signed [SUM_W-1:0]    sum_reg [3];
    vna_result_t                result_reg;

    logic                       accept;
    logic                       v_we;
    logic                       f_we;
    logic        [VW_W-1:0]     v_rdata;
    logic        [FW_W-1:0]     f_rdata;
    logic        [VA_W-1:0]     v_raddr;
    logic        [CORNER_W-1:0] v_rcorner;
    logic        [CORNER_W-1:0] fc0;
    logic        [CORNER_W-1:0] fc1;
    logic        [CORNER_W-1:0] fc2;
    logic        [CMP_W-1:0]    vc_ext;
    logic        [CMP_W-1:0]    c0_ext;
    logic        [CMP_W-1:0]    c1_ext;
    logic        [CMP_W-1:0]    c2_ext;
    logic        [CMP_W-1:0]    rc_ext;
    logic                       face_hit;
    logic                       last_face;
    logic signed [DIFF_W-1:0]   op_a;
    logic signed [DIFF_W-1:0]   op_b;
    logic signed [SUM_W-1:0]    addend;
    logic        [FC_W+FCOUT_W-1:0] shared_ext;
    vna_norm_t                  nres;

    assign accept = start && !busy;
    assign v_we   = accept && item.mode == MODE_VERTEX && vcount_reg < VC_W'(MAX_VERTICES);
    assign f_we   = accept && item.mode == MODE_FACE && fcount_reg < FC_W'(MAX_FACES);

    assign {fc0, fc1, fc2} = f_rdata;
    assign vc_ext = CMP_W'(vcount_reg);
    assign c0_ext = CMP_W'(fc0);
    assign c1_ext = CMP_W'(fc1);
    assign c2_ext = CMP_W'(fc2);
    assign face_hit = c0_ext < vc_ext && c1_ext < vc_ext && c2_ext < vc_ext
                   && (fc0 == qid_reg || fc1 == qid_reg || fc2 == qid_reg);
    assign last_face = (j_reg + 1'b1) >= fcount_reg;

    always_comb
    begin
        priority case (state_reg)
            W_FCHK:  v_rcorner = fc0;
            W_VA:    v_rcorner = i1_reg;
            default: v_rcorner = i2_reg;
        endcase
    end
    assign rc_ext  = CMP_W'(v_rcorner);
    assign v_raddr = rc_ext[VA_W-1:0];

    vna_ram #(
        .WIDTH (VW_W),
        .DEPTH (MAX_VERTICES)
    ) u_vram (
        .clk   (clk),
        .we    (v_we),
        .waddr (vcount_reg[VA_W-1:0]),
        .wdata ({item.coord_x, item.coord_y, item.coord_z}),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    vna_ram #(
        .WIDTH (FW_W),
        .DEPTH (MAX_FACES)
    ) u_fram (
        .clk   (clk),
        .we    (f_we),
        .waddr (fcount_reg[FA_W-1:0]),
        .wdata ({item.corner_a, item.corner_b, item.corner_c}),
        .raddr (j_reg[FA_W-1:0]),
        .rdata (f_rdata)
    );

    // Product order: x gets ay*bz - az*by, y gets az*bx - ax*bz,
    // z gets ax*by - ay*bx; odd steps subtract.
    always_comb
    begin
        unique case (step_reg)
            3'd0:    begin op_a = a_reg[1]; op_b = b_reg[2]; end
            3'd1:    begin op_a = a_reg[2]; op_b = b_reg[1]; end
            3'd2:    begin op_a = a_reg[2]; op_b = b_reg[0]; end
            3'd3:    begin op_a = a_reg[0]; op_b = b_reg[2]; end
            3'd4:    begin op_a = a_reg[0]; op_b = b_reg[1]; end
            default: begin op_a = a_reg[1]; op_b = b_reg[0]; end
        endcase
    end
    assign addend = SUM_W'(mul_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            W_IDLE:
            begin
                if (accept && item.mode == MODE_QUERY)
                begin
                    state_next = (fcount_reg == '0) ? W_NSTART : W_FACE;
                end
            end
            W_FACE:   state_next = W_FCHK;
            W_FCHK:
            begin
                if (face_hit)
                begin
                    state_next = W_VA;
                end
                else
                begin
                    state_next = last_face ? W_NSTART : W_FACE;
                end
            end
            W_VA:     state_next = W_VB;
            W_VB:     state_next = W_VC;
            W_VC:     state_next = W_DIFF;
            W_DIFF:   state_next = W_MUL;
            W_MUL:
            begin
                if (step_reg == 3'd5)
                begin
                    state_next = W_NEXT;
                end
            end
            W_NEXT:   state_next = last_face ? W_NSTART : W_FACE;
            W_NSTART: state_next = W_NORM;
            W_NORM:
            begin
                if (nres.done)
                begin
                    state_next = W_OUT;
                end
            end
            W_OUT:    state_next = W_IDLE;
            default:  state_next = W_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= W_IDLE;
            vcount_reg  <= '0;
            fcount_reg  <= '0;
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mul_vld_reg <= (state_reg == W_MUL);
            if (v_we)
            begin
                vcount_reg <= vcount_reg + 1'b1;
            end
            if (f_we)
            begin
                fcount_reg <= fcount_reg + 1'b1;
            end
            if (accept && item.mode == MODE_NEW)
            begin
                vcount_reg <= '0;
                fcount_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_vld_reg)
        begin
            if (sel_reg[0])
            begin
                sum_reg[sel_reg[2:1]] <= sum_reg[sel_reg[2:1]] - addend;
            end
            else
            begin
                sum_reg[sel_reg[2:1]] <= sum_reg[sel_reg[2:1]] + addend;
            end
        end
        unique case (state_reg)
            W_IDLE:
            begin
                qid_reg    <= item.corner_a;
                j_reg      <= '0;
                shared_reg <= '0;
                for (int k = 0; k < 3; k++)
                begin
                    sum_reg[k] <= '0;
                end
            end
            W_FCHK:
            begin
                i1_reg   <= fc1;
                i2_reg   <= fc2;
                step_reg <= 3'd0;
                if (face_hit)
                begin
                    shared_reg <= shared_reg + 1'b1;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            W_VA: v0_reg <= v_rdata;
            W_VB: v1_reg <= v_rdata;
            W_VC: v2_reg <= v_rdata;
            W_DIFF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    a_reg[k] <= DIFF_W'($signed(v0_reg[(2-k)*COORD_W +: COORD_W]))
                              - DIFF_W'($signed(v2_reg[(2-k)*COORD_W +: COORD_W]));
                    b_reg[k] <= DIFF_W'($signed(v2_reg[(2-k)*COORD_W +: COORD_W]))
                              - DIFF_W'($signed(v1_reg[(2-k)*COORD_W +: COORD_W]));
                end
            end
            W_MUL:
            begin
                mul_reg  <= op_a * op_b;
                sel_reg  <= step_reg;
                step_reg <= step_reg + 3'd1;
            end
            W_NEXT: j_reg <= j_reg + 1'b1;
            W_NORM:
            begin
                result_reg.vertex_id  <= qid_reg;
                result_reg.normal_x   <= nres.normal_x;
                result_reg.normal_y   <= nres.normal_y;
                result_reg.normal_z   <= nres.normal_z;
                result_reg.face_count <= shared_ext[FCOUT_W-1:0];
                result_reg.degenerate <= nres.degenerate;
            end
            default:
            begin
                step_reg <= 3'd0;
            end
        endcase
    end

    assign shared_ext = (FC_W + FCOUT_W)'(shared_reg);

    vna_norm #(
        .SUM_W (SUM_W)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == W_NSTART),
        .sum_x (sum_reg[0]),
        .sum_y (sum_reg[1]),
        .sum_z (sum_reg[2]),
        .res   (nres)
    );

    assign busy   = (state_reg != W_IDLE);
    assign done   = (state_reg == W_OUT);
    assign result = result_reg;

`ifndef SYNTHESIS
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a query");
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.mode == MODE_QUERY) |=> busy)
        else $error("query accepted without going busy");
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.degenerate) |->
        (result.normal_x == '0 && result.normal_y == '0 && result.normal_z == '0))
        else $error("degenerate result with a non-zero normal");
    a_vcount_cap: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= VC_W'(MAX_VERTICES))
        else $error("vertex count beyond capacity");
    a_norm_once: assert property (@(posedge clk) disable iff (!rst_n)
        nres.done |-> state_reg == W_NORM)
        else $error("normaliser finished outside a query");
`endif

endmodule
`default_nettype wire

[tb/vna_normal_checker.sv]
`timescale 1ns / 1ps
module vna_normal_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire vna_pkg::vna_item_t   item,
    input  wire logic                 done,
    input  wire vna_pkg::vna_result_t result,
    output int                        fail_count,
    output int                        pending,
    output int                        queries_seen
);
    import vna_pkg::*;

    localparam int NV = MAX_VERTICES_DEF;
    localparam int NF = MAX_FACES_DEF;

    logic signed [31:0] pos_x [NV];
    logic signed [31:0] pos_y [NV];
    logic signed [31:0] pos_z [NV];
    logic [9:0] tri_a [NF];
    logic [9:0] tri_b [NF];
    logic [9:0] tri_c [NF];
    int unsigned n_vert;
    int unsigned n_tri;
    vna_result_t normal_q[$];

    initial fail_count = 0;
    initial queries_seen = 0;
    assign pending = normal_q.size();

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic vna_result_t averaged_normal(input logic [9:0] vid);
        vna_result_t res;
        logic signed [127:0] acc [3];
        logic signed [127:0] ax, ay, az, bx, by, bz;
        logic [127:0] mag [3];
        logic neg [3];
        logic [63:0] m, q, l;
        int unsigned shared;
        logic [9:0] i0, i1, i2;
        acc[0] = 0; acc[1] = 0; acc[2] = 0;
        shared = 0;
        for (int j = 0; j < n_tri; j++)
        begin
            i0 = tri_a[j]; i1 = tri_b[j]; i2 = tri_c[j];
            if (i0 >= n_vert || i1 >= n_vert || i2 >= n_vert) continue;
            if (i0 != vid && i1 != vid && i2 != vid) continue;
            shared++;
            ax = 128'(pos_x[i0]) - 128'(pos_x[i2]);
            ay = 128'(pos_y[i0]) - 128'(pos_y[i2]);
            az = 128'(pos_z[i0]) - 128'(pos_z[i2]);
            bx = 128'(pos_x[i2]) - 128'(pos_x[i1]);
            by = 128'(pos_y[i2]) - 128'(pos_y[i1]);
            bz = 128'(pos_z[i2]) - 128'(pos_z[i1]);
            acc[0] = acc[0] + ay * bz - az * by;
            acc[1] = acc[1] + az * bx - ax * bz;
            acc[2] = acc[2] + ax * by - ay * bx;
        end
        // The sum is negated before normalising.
        for (int k = 0; k < 3; k++)
        begin
            acc[k] = -acc[k];
            neg[k] = acc[k][127];
            mag[k] = neg[k] ? -acc[k] : acc[k];
        end
        while (mag[0] >= (128'd1 << 30) || mag[1] >= (128'd1 << 30)
               || mag[2] >= (128'd1 << 30))
            for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
        res.vertex_id  = vid;
        res.face_count = shared[11:0];
        if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0)
        begin
            res.normal_x = 0; res.normal_y = 0; res.normal_z = 0;
            res.degenerate = 1'b1;
        end
        else
        begin
            l = mag[0][63:0] * mag[0][63:0] + mag[1][63:0] * mag[1][63:0]
                + mag[2][63:0] * mag[2][63:0];
            m = int_sqrt(l);
            for (int k = 0; k < 3; k++)
            begin
                q = (mag[k][63:0] * 64'd16384 + m / 2) / m;
                if (neg[k]) q = -q;
                if (k == 0) res.normal_x = q[15:0];
                else if (k == 1) res.normal_y = q[15:0];
                else res.normal_z = q[15:0];
            end
            res.degenerate = 1'b0;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vna_result_t want;
        if (!rst_n)
        begin
            n_vert <= 0;
            n_tri  <= 0;
        end
        else
        begin
            if (done)
            begin
                queries_seen <= queries_seen + 1;
                if (normal_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result word %p", result);
                end
                else
                begin
                    want = normal_q.pop_front();
                    if (result !== want)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected %p got %p", want, result);
                    end
                end
            end
            if (start && !busy)
            begin
                case (item.mode)
                    MODE_VERTEX:
                        if (n_vert < NV)
                        begin
                            pos_x[n_vert] = item.coord_x;
                            pos_y[n_vert] = item.coord_y;
                            pos_z[n_vert] = item.coord_z;
                            n_vert <= n_vert + 1;
                        end
                    MODE_FACE:
                        if (n_tri < NF)
                        begin
                            tri_a[n_tri] = item.corner_a;
                            tri_b[n_tri] = item.corner_b;
                            tri_c[n_tri] = item.corner_c;
                            n_tri <= n_tri + 1;
                        end
                    MODE_QUERY:
                        normal_q = {normal_q, averaged_normal(item.corner_a)};
                    default:
                    begin
                        n_vert <= 0;
                        n_tri  <= 0;
                    end
                endcase
            end
        end
    end

endmodule

[tb/vertex_normal_averager_tb.sv]
`timescale 1ns / 1ps
module vertex_normal_averager_tb;
    import vna_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    vna_item_t item;
    logic busy;
    logic done;
    vna_result_t result;
    int fail_count;
    int pending;
    int queries_seen;
    int words_sent;

    vertex_normal_averager dut (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item),
        .busy(busy), .done(done), .result(result)
    );

    vna_normal_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .fail_count(fail_count),
        .pending(pending), .queries_seen(queries_seen)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Each word first waits a random idle gap, which may be empty, except in runs with no idling.
    // Start stays high from one word to the next when there is no gap.
    task automatic send_word(input vna_mode_t md, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z,
                             input logic [9:0] a, input logic [9:0] b,
                             input logic [9:0] c, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : int'($urandom_range(9));
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.mode     <= md;
        item.coord_x  <= x;
        item.coord_y  <= y;
        item.coord_z  <= z;
        item.corner_a <= a;
        item.corner_b <= b;
        item.corner_c <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        words_sent++;
    endtask

    task automatic put_vertex(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input bit ng);
        send_word(MODE_VERTEX, x, y, z, 10'd0, 10'd0, 10'd0, ng);
    endtask

    task automatic put_face(input logic [9:0] a, input logic [9:0] b,
                            input logic [9:0] c, input bit ng);
        send_word(MODE_FACE, $urandom, $urandom, $urandom, a, b, c, ng);
    endtask

    task automatic ask(input logic [9:0] a, input bit ng);
        send_word(MODE_QUERY, $urandom, $urandom, $urandom, a, 10'($urandom),
                  10'($urandom), ng);
    endtask

    task automatic new_object(input bit ng);
        send_word(MODE_NEW, 32'd0, 32'd0, 32'd0, 10'd0, 10'd0, 10'd0, ng);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
            2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(200)) - 100);
        endcase
    endfunction

    initial
    begin
        int nv, nf;
        bit ng;
        start = 0;
        item = '0;
        words_sent = 0;
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extreme coordinates, three shared vertices, an invalid face,
        // an unloaded query, a query on an empty object and a zero-area face.
        put_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b0);
        put_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        put_vertex(32'h0, 32'h0, 32'h8000_0000, 1'b0);
        put_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
        put_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
        put_face(10'd0, 10'd1, 10'd2, 1'b0);
        put_face(10'd2, 10'd1, 10'd0, 1'b1);
        put_face(10'd0, 10'd3, 10'd1023, 1'b0);
        put_face(10'd3, 10'd4, 10'd4, 1'b0);
        ask(10'd0, 1'b0);
        ask(10'd2, 1'b1);
        ask(10'd3, 1'b0);
        ask(10'd4, 1'b0);
        ask(10'd1023, 1'b0);
        ask(10'd5, 1'b0);
        new_object(1'b0);
        ask(10'd0, 1'b0);
        put_face(10'h3ff, 10'h3ff, 10'h3ff, 1'b0);
        ask(10'h3ff, 1'b0);

        // Random meshes: small objects, mostly well-formed faces.
        while (words_sent < 268)
        begin
            ng = ($urandom_range(3) == 0);
            new_object(ng);
            nv = $urandom_range(3, 8);
            nf = $urandom_range(1, 8);
            for (int i = 0; i < nv; i++) put_vertex(rand_coord(), rand_coord(),
                                                   rand_coord(), ng);
            for (int i = 0; i < nf; i++)
                if ($urandom_range(9) == 0)
                    put_face(10'($urandom), 10'($urandom), 10'($urandom), ng);
                else
                    put_face(10'($urandom_range(nv - 1)), 10'($urandom_range(nv - 1)),
                             10'($urandom_range(nv)), ng);
            repeat ($urandom_range(2, 5))
                ask($urandom_range(9) == 0 ? 10'($urandom) : 10'($urandom_range(nv)), ng);
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("sent %0d words and checked %0d normal queries on small random meshes",
                 words_sent, queries_seen);
        if (fail_count == 0)
            $display("vertex_normal_averager_tb: clean");
        else
            $display("vertex_normal_averager_tb: errors");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("vertex_normal_averager_tb: errors");
        $finish;
    end

endmodule
